/* hw/rtl/clock_shift_state_lookup_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the clock-shift state lookup block
// Shorthand for the concurrent checks used inside the RTL modules.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SHIFT_STATE_LOOKUP_ASSERT_SVH
`define CLOCK_SHIFT_STATE_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define CSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

/* hw/rtl/csl_pkg.sv */
// ----------------------------------------------------------------------------
// Clock-shift state lookup package
// Field widths, operation codes, controller states, command and status
// bundles, and the digit arithmetic shared by the modules.
// ----------------------------------------------------------------------------
package csl_pkg;

   // Field widths of the channels.
   localparam int FUNC_W   = 3;
   localparam int SITE_W   = 5;
   localparam int INDEX_W  = 10;
   localparam int WORD_W   = 64;
   localparam int RESULT_W = 11;
   localparam int COEF_W   = 2;

   // Number of site codes that a site field can carry.
   localparam int SITE_CODES = 32;

   // Widest table address that the depth range can need.
   localparam int ADDR_W_MAX = 16;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_MAX_SITES   = 32;

   // Digit encodings.
   localparam logic [COEF_W-1:0] DIGIT_ZERO = 2'd0;
   localparam logic [COEF_W-1:0] DIGIT_ONE  = 2'd1;
   localparam logic [COEF_W-1:0] DIGIT_TWO  = 2'd2;

   // Item kinds.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD         = 3'd0,
      FUNC_LOWER_RAISE  = 3'd1,
      FUNC_RAISE_RAISE  = 3'd2,
      FUNC_LOWER_LOWER  = 3'd3,
      FUNC_RAISE_Z      = 3'd4,
      FUNC_LOWER_Z      = 3'd5,
      FUNC_RAISE        = 3'd6,
      FUNC_LOWER        = 3'd7
   } func_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_FETCH,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic reduce_step;
      logic mem_write;
      logic mem_read_idx;
      logic take_word;
      logic scan_start;
      logic scan_issue;
      logic set_found;
      logic set_not_found;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_over;
      logic is_load;
      logic z_zero;
      logic scan_done;
      logic hit;
   } status_type;

   // Map from a site code to its site on the chain.
   typedef logic [SITE_CODES-1:0][SITE_W-1:0] site_map_type;

   // Builds the site-code map for a chain of n sites without dividing.
   function automatic site_map_type site_map_table(int n);
      site_map_type        t;
      logic [SITE_W-1:0]   r;
      r = '0;
      for (int s = 0; s < SITE_CODES; s++) begin
         t[s] = r;
         if (int'(r) + 1 >= n) begin
            r = '0;
         end else begin
            r = r + 5'd1;
         end
      end
      return t;
   endfunction

   // Digit at one site of a state word.
   function automatic logic [COEF_W-1:0] digit_at(logic [WORD_W-1:0] w,
                                                  logic [SITE_W-1:0] s);
      return w[{s, 1'b0} +: COEF_W];
   endfunction

   // Raise (up set) or lower one digit mod 3; the unused code 3 becomes 0.
   function automatic logic [WORD_W-1:0] apply_op(logic [WORD_W-1:0] w,
                                                  logic [SITE_W-1:0] s,
                                                  logic              up);
      logic [COEF_W-1:0] d;
      logic [COEF_W-1:0] nd;
      logic [WORD_W-1:0] r;
      r  = w;
      d  = w[{s, 1'b0} +: COEF_W];
      nd = DIGIT_ZERO;
      if (up) begin
         if (d == DIGIT_ZERO) begin
            nd = DIGIT_ONE;
         end else if (d == DIGIT_ONE) begin
            nd = DIGIT_TWO;
         end
      end else begin
         if (d == DIGIT_ZERO) begin
            nd = DIGIT_TWO;
         end else if (d == DIGIT_TWO) begin
            nd = DIGIT_ONE;
         end
      end
      r[{s, 1'b0} +: COEF_W] = nd;
      return r;
   endfunction

endpackage

/* hw/rtl/csl_if.sv */
// ----------------------------------------------------------------------------
// Clock-shift state lookup channels
// Valid/ready channels for request items, result items and the size register.
// ----------------------------------------------------------------------------

// Request channel: one load or operator item.
interface csl_req_if import csl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SITE_W-1:0]   site_i;
   logic [SITE_W-1:0]   site_j;
   logic [INDEX_W-1:0]  state_index;
   logic [WORD_W-1:0]   entry_word;

   modport source (output valid, func, site_i, site_j, state_index, entry_word,
                   input ready);
   modport sink   (input valid, func, site_i, site_j, state_index, entry_word,
                   output ready);
endinterface

// Result channel: one lookup result item.
interface csl_rsp_if import csl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] result_index;
   logic [COEF_W-1:0]   coefficient;

   modport source (output valid, result_index, coefficient, input ready);
   modport sink   (input valid, result_index, coefficient, output ready);
endinterface

// Register write channel for the table size.
interface csl_csr_if import csl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/clock_shift_state_lookup.sv */
// ----------------------------------------------------------------------------
// Clock-shift state lookup
// Table of three-valued basis-state words with raise/lower operators and a
// linear search for the resulting word.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A load item is written to the table
// once TABLE_DEPTH has been taken from state_index as often as it fits, which
// happens only when the depth is below 1024. An operator item runs the same
// index reduction and then searches at most min(table_size, TABLE_DEPTH)
// entries; a z kind whose digit at site j is 0 skips the search. The linear
// search reads one table entry per cycle through the single registered read
// port of the table. The result sits in an output register until taken; the
// size register can be written at any cycle through its own channel, which is
// always ready.
module clock_shift_state_lookup import csl_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int MAX_SITES   = DEFAULT_MAX_SITES
) (
   input  logic       clock,
   input  logic       reset,
   csl_req_if.sink    req_bus,
   csl_rsp_if.source  rsp_bus,
   csl_csr_if.sink    csr_bus
);

   cmd_type    cmd;
   status_type status;

   // The size register takes a write in any cycle.
   assign csr_bus.ready = 1'b1;

   // Sequencer for the handshakes and the search.
   csl_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, operators and result registers.
   csl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_SITES   (MAX_SITES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_bus.func),
      .req_site_i       (req_bus.site_i),
      .req_site_j       (req_bus.site_j),
      .req_state_index  (req_bus.state_index),
      .req_entry_word   (req_bus.entry_word),
      .csr_write        (csr_bus.valid),
      .csr_data         (csr_bus.data),
      .rsp_result_index (rsp_bus.result_index),
      .rsp_coefficient  (rsp_bus.coefficient)
   );

endmodule

/* hw/rtl/csl_datapath.sv */
// ----------------------------------------------------------------------------
// Clock-shift state lookup datapath
// Holds the state table, the captured item, the digit operators, the search
// counter and the result registers, all steered by controller commands.
// ----------------------------------------------------------------------------
module csl_datapath import csl_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int MAX_SITES   = DEFAULT_MAX_SITES
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SITE_W-1:0]   req_site_i,
   input  logic [SITE_W-1:0]   req_site_j,
   input  logic [INDEX_W-1:0]  req_state_index,
   input  logic [WORD_W-1:0]   req_entry_word,
   input  logic                csr_write,
   input  logic [RESULT_W-1:0] csr_data,
   output logic [RESULT_W-1:0] rsp_result_index,
   output logic [COEF_W-1:0]   rsp_coefficient
);

   localparam int                 ADDR_W    = $clog2(TABLE_DEPTH);
   localparam logic [31:0]        DEPTH_U   = 32'(TABLE_DEPTH);
   localparam logic [INDEX_W-1:0] DEPTH_IDX = INDEX_W'(TABLE_DEPTH);
   localparam site_map_type       SITE_MAP  = site_map_table(MAX_SITES);

   logic [WORD_W-1:0]   mem [TABLE_DEPTH];
   logic [WORD_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;

   logic [FUNC_W-1:0]   func_ff;
   logic [SITE_W-1:0]   site_i_ff;
   logic [SITE_W-1:0]   site_j_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [WORD_W-1:0]   entry_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [COEF_W-1:0]   coef_ff;
   logic [RESULT_W-1:0] scan_ff;
   logic                pend_ff;
   logic [RESULT_W-1:0] table_size_ff;
   logic [RESULT_W-1:0] res_index_ff;
   logic [RESULT_W-1:0] rsp_index_ff;
   logic [COEF_W-1:0]   rsp_coef_ff;

   logic [ADDR_W_MAX-1:0] idx_wide;
   logic [ADDR_W_MAX-1:0] scan_wide;
   logic [ADDR_W-1:0]     idx_addr;
   logic [ADDR_W-1:0]     scan_addr;
   logic [SITE_W-1:0]     si;
   logic [SITE_W-1:0]     sj;
   func_type              kind;
   logic [WORD_W-1:0]     word_in;
   logic [COEF_W-1:0]     coef_in;
   logic                  is_z;

   // Table addresses from the reduced index and the search counter.
   assign idx_wide  = ADDR_W_MAX'(idx_ff);
   assign scan_wide = ADDR_W_MAX'(scan_ff);
   assign idx_addr  = idx_wide[ADDR_W-1:0];
   assign scan_addr = scan_wide[ADDR_W-1:0];
   assign rd_addr   = cmd.mem_read_idx ? idx_addr : scan_addr;

   // State table with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[idx_addr] <= entry_ff;
      end
      if (cmd.mem_read_idx || cmd.scan_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Captured item; the index is brought below the depth one step a cycle.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         site_i_ff <= req_site_i;
         site_j_ff <= req_site_j;
         idx_ff    <= req_state_index;
         entry_ff  <= req_entry_word;
      end else if (cmd.reduce_step) begin
         idx_ff <= idx_ff - DEPTH_IDX;
      end
   end

   // Operators applied to the fetched word: the site j operator comes first.
   always_comb begin
      kind    = func_type'(func_ff);
      si      = SITE_MAP[site_i_ff];
      sj      = SITE_MAP[site_j_ff];
      coef_in = DIGIT_ZERO;
      is_z    = 1'b0;
      case (kind)
         FUNC_LOWER_RAISE: word_in = apply_op(apply_op(rd_data_ff, sj, 1'b1), si, 1'b0);
         FUNC_RAISE_RAISE: word_in = apply_op(apply_op(rd_data_ff, sj, 1'b1), si, 1'b1);
         FUNC_LOWER_LOWER: word_in = apply_op(apply_op(rd_data_ff, sj, 1'b0), si, 1'b0);
         FUNC_RAISE_Z, FUNC_LOWER_Z: begin
            is_z    = 1'b1;
            coef_in = digit_at(rd_data_ff, sj);
            word_in = apply_op(rd_data_ff, si, kind == FUNC_RAISE_Z);
         end
         FUNC_RAISE:       word_in = apply_op(rd_data_ff, si, 1'b1);
         default:          word_in = apply_op(rd_data_ff, si, 1'b0);
      endcase
   end

   // Search target, coefficient and result registers.
   always_ff @(posedge clock) begin
      if (cmd.take_word) begin
         word_ff <= word_in;
         coef_ff <= coef_in;
      end
      if (cmd.set_found) begin
         res_index_ff <= scan_ff - 11'd1;
      end else if (cmd.set_not_found) begin
         res_index_ff <= table_size_ff;
      end
      if (cmd.out_load) begin
         rsp_index_ff <= res_index_ff;
         rsp_coef_ff  <= coef_ff;
      end
   end

   // Search counter, pending-compare flag and the size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         pend_ff       <= 1'b0;
         table_size_ff <= '0;
      end else begin
         if (cmd.scan_start) begin
            scan_ff <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.scan_issue) begin
            scan_ff <= scan_ff + 11'd1;
            pend_ff <= 1'b1;
         end
         if (csr_write) begin
            table_size_ff <= csr_data;
         end
      end
   end

   // Status for the controller.
   always_comb begin
      status.idx_over  = 32'(idx_ff) >= DEPTH_U;
      status.is_load   = func_type'(func_ff) == FUNC_LOAD;
      status.z_zero    = is_z && (coef_in == DIGIT_ZERO);
      status.scan_done = (scan_ff >= table_size_ff) || (32'(scan_ff) >= DEPTH_U);
      status.hit       = pend_ff && (rd_data_ff == word_ff);
   end

   assign rsp_result_index = rsp_index_ff;
   assign rsp_coefficient  = rsp_coef_ff;

endmodule

/* hw/rtl/csl_controller.sv */
// ----------------------------------------------------------------------------
// Clock-shift state lookup controller
// Sequences capture, index reduction, fetch, linear search and result hand-off
// for one item at a time, and owns the channel handshakes.
// ----------------------------------------------------------------------------
`include "clock_shift_state_lookup_assert.svh"

module csl_controller import csl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // State and output-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands; no item is taken while in reset.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.idx_over) begin
               cmd.reduce_step = 1'b1;
            end else if (status.is_load) begin
               cmd.mem_write = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.mem_read_idx = 1'b1;
               state_in         = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.take_word = 1'b1;
            if (status.z_zero) begin
               cmd.set_not_found = 1'b1;
               state_in          = ST_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The compare covers the entry read in the previous cycle.
            if (status.hit) begin
               cmd.set_found = 1'b1;
               state_in      = ST_FINISH;
            end else if (status.scan_done) begin
               cmd.set_not_found = 1'b1;
               state_in          = ST_FINISH;
            end else begin
               cmd.scan_issue = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register holds a result until it is taken.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A result is never loaded over one that still waits.
   `CSL_ASSERT_SAME(a_out_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready)
   // A loaded result is offered in the next cycle.
   `CSL_ASSERT_NEXT(a_result_shown, clock, reset, cmd.out_load, rsp_valid_ff)
   // An accepted item always moves the controller out of idle.
   `CSL_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, state_ff != ST_IDLE)

endmodule

/* tb/sv/clock_shift_state_lookup_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock-shift state lookup testbench
// Drives load and operator items into the block, keeps its own copy of the
// state table and the size register, predicts the index and coefficient of
// every lookup, and checks each result item in order. Both channel sides
// idle and stall at random, and the size register is changed between phases.
// ----------------------------------------------------------------------------
module clock_shift_state_lookup_test import csl_pkg::*; ();

   localparam int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
   localparam int MAX_SITES    = DEFAULT_MAX_SITES;
   localparam int FILL_ENTRIES = 128;
   localparam int RANDOM_ITEMS = 380;
   localparam int IDLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES = 20;
   localparam int LIMIT_CYCLES = 500_000;
   localparam int REPORT_MAX   = 10;
   localparam int HOLD_CYCLES  = 300;

   // Unused digit encoding, and the widest value the size register takes.
   localparam logic [COEF_W-1:0]   DIGIT_UNUSED      = 2'd3;
   localparam logic [RESULT_W-1:0] SIZE_BEYOND_DEPTH = '1;

   typedef struct packed {
      logic [RESULT_W-1:0] result_index;
      logic [COEF_W-1:0]   coefficient;
   } lookup_type;

   logic clock;
   logic reset;

   csl_req_if req_bus ();
   csl_rsp_if rsp_bus ();
   csl_csr_if csr_bus ();

   // Our copy of the block's table and size register.
   logic [WORD_W-1:0]   table_words [TABLE_DEPTH];
   logic [RESULT_W-1:0] table_size_now;

   // Lookups accepted by the block whose results have not come back yet.
   lookup_type awaited_lookups [$];

   // Word family used to build tables in which operators find their targets.
   logic [WORD_W-1:0] family_base;
   logic [SITE_W-1:0] active_sites [3];

   int failures;
   int items_sent;
   int rsp_hold_cycles;
   bit no_idle;

   clock_shift_state_lookup #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_SITES   (MAX_SITES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Free-running 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Raise or lower one digit mod 3; the unused encoding goes to zero.
   function automatic logic [WORD_W-1:0] step_digit(logic [WORD_W-1:0] w,
                                                    logic [SITE_W-1:0] s,
                                                    bit                up);
      logic [COEF_W-1:0] d;
      logic [COEF_W-1:0] nd;
      d = w[2 * int'(s) +: COEF_W];
      case (d)
         DIGIT_ZERO: nd = up ? DIGIT_ONE : DIGIT_TWO;
         DIGIT_ONE:  nd = up ? DIGIT_TWO : DIGIT_ZERO;
         DIGIT_TWO:  nd = up ? DIGIT_ZERO : DIGIT_ONE;
         default:    nd = DIGIT_ZERO;
      endcase
      w[2 * int'(s) +: COEF_W] = nd;
      return w;
   endfunction

   // Expected result of one operator item against the current table.
   function automatic lookup_type predict_lookup(func_type          f,
                                                 logic [SITE_W-1:0] si,
                                                 logic [SITE_W-1:0] sj,
                                                 logic [INDEX_W-1:0] idx);
      logic [WORD_W-1:0] w;
      lookup_type        r;
      int                span;
      w = table_words[idx];
      r.coefficient  = DIGIT_ZERO;
      r.result_index = table_size_now;
      case (f)
         FUNC_LOWER_RAISE: w = step_digit(step_digit(w, sj, 1'b1), si, 1'b0);
         FUNC_RAISE_RAISE: w = step_digit(step_digit(w, sj, 1'b1), si, 1'b1);
         FUNC_LOWER_LOWER: w = step_digit(step_digit(w, sj, 1'b0), si, 1'b0);
         FUNC_RAISE_Z, FUNC_LOWER_Z: begin
            r.coefficient = w[2 * int'(sj) +: COEF_W];
            // A zero digit under the z operator kills the state outright.
            if (r.coefficient == DIGIT_ZERO) begin
               return r;
            end
            w = step_digit(w, si, f == FUNC_RAISE_Z);
         end
         FUNC_RAISE: w = step_digit(w, si, 1'b1);
         default:    w = step_digit(w, si, 1'b0);
      endcase
      // First match wins; the search never runs past the table depth.
      span = (int'(table_size_now) < TABLE_DEPTH) ? int'(table_size_now) : TABLE_DEPTH;
      for (int k = 0; k < span; k++) begin
         if (table_words[k] == w) begin
            r.result_index = RESULT_W'(k);
            break;
         end
      end
      return r;
   endfunction

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= REPORT_MAX) begin
         $display("%s", msg);
      end
   endfunction

   // Mostly back-to-back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Start a new word family: a random base and three sites that vary.
   function automatic void new_family();
      family_base = {$urandom, $urandom};
      foreach (active_sites[n]) begin
         active_sites[n] = SITE_W'($urandom_range(0, SITE_CODES - 1));
      end
   endfunction

   function automatic logic [WORD_W-1:0] family_word();
      logic [WORD_W-1:0] w;
      w = family_base;
      foreach (active_sites[n]) begin
         if ($urandom_range(0, 7) == 0) begin
            w[2 * int'(active_sites[n]) +: COEF_W] = DIGIT_UNUSED;
         end else begin
            w[2 * int'(active_sites[n]) +: COEF_W] = COEF_W'($urandom_range(0, 2));
         end
      end
      return w;
   endfunction

   // Mostly a site that the family varies, sometimes any site.
   function automatic logic [SITE_W-1:0] pick_site();
      if ($urandom_range(0, 4) == 0) begin
         return SITE_W'($urandom_range(0, SITE_CODES - 1));
      end
      return active_sites[$urandom_range(0, 2)];
   endfunction

   function automatic func_type random_operator();
      return func_type'(FUNC_W'($urandom_range(1, 7)));
   endfunction

   // Offer one item and wait for it to be taken; record its effect on accept.
   task automatic send_item(input func_type           f,
                            input logic [SITE_W-1:0]  si,
                            input logic [SITE_W-1:0]  sj,
                            input logic [INDEX_W-1:0] idx,
                            input logic [WORD_W-1:0]  word);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= f;
      req_bus.site_i      <= si;
      req_bus.site_j      <= sj;
      req_bus.state_index <= idx;
      req_bus.entry_word  <= word;
      do @(posedge clock); while (!req_bus.ready);
      if (f == FUNC_LOAD) begin
         table_words[idx] = word;
      end else begin
         awaited_lookups.push_back(predict_lookup(f, si, sj, idx));
      end
      items_sent++;
   endtask

   task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] word);
      send_item(FUNC_LOAD, SITE_W'($urandom), SITE_W'($urandom), idx, word);
   endtask

   task automatic apply_operator(input func_type           f,
                                 input logic [SITE_W-1:0]  si,
                                 input logic [SITE_W-1:0]  sj,
                                 input logic [INDEX_W-1:0] idx);
      send_item(f, si, sj, idx, {$urandom, $urandom});
   endtask

   // Stop sending, wait for every result, then let a trailing load finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited_lookups.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_table_size(input logic [RESULT_W-1:0] value);
      settle();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid  <= 1'b0;
      table_size_now = value;
   endtask

   // The size register comes out of reset at zero, so nothing can be found.
   task automatic test_reset_size();
      load_entry('0, '0);
      apply_operator(FUNC_RAISE, '0, '0, '0);
      apply_operator(FUNC_RAISE_Z, 5'd1, '0, '0);
   endtask

   // Hand-built table that hits each operator kind and each corner case.
   task automatic test_directed_cases();
      load_entry(10'd0, 64'h0);
      load_entry(10'd1, 64'h1);
      load_entry(10'd2, 64'h2);
      load_entry(10'd3, 64'h4000_0000_0000_0000);
      load_entry(10'd4, '1);
      load_entry(10'd5, 64'h5);
      load_entry(10'd6, 64'h8000_0000_0000_0000);
      load_entry('1, 64'h3);
      write_table_size(RESULT_W'(7));
      // Single-site raise and lower, including the wrap from two to zero.
      apply_operator(FUNC_RAISE, 5'd0, 5'd0, 10'd0);
      apply_operator(FUNC_LOWER, 5'd0, 5'd0, 10'd0);
      apply_operator(FUNC_RAISE, 5'd0, 5'd0, 10'd2);
      apply_operator(FUNC_LOWER, 5'd0, 5'd0, 10'd1);
      // The unused encoding is cleared by either direction.
      apply_operator(FUNC_RAISE, 5'd0, 5'd9, '1);
      apply_operator(FUNC_LOWER, 5'd0, 5'd9, '1);
      apply_operator(FUNC_RAISE_RAISE, 5'd1, 5'd0, 10'd0);
      apply_operator(FUNC_LOWER_RAISE, 5'd31, 5'd31, 10'd3);
      apply_operator(FUNC_LOWER_LOWER, 5'd31, 5'd0, 10'd0);
      // Z kinds: zero digit, digits one and two, and the unused encoding.
      apply_operator(FUNC_RAISE_Z, 5'd31, 5'd0, 10'd0);
      apply_operator(FUNC_LOWER_Z, 5'd31, 5'd0, 10'd1);
      apply_operator(FUNC_RAISE_Z, 5'd0, 5'd0, 10'd2);
      apply_operator(FUNC_LOWER_Z, 5'd0, 5'd5, 10'd4);
      // Single-operator kinds must ignore site j.
      apply_operator(FUNC_RAISE, 5'd31, 5'd31, 10'd3);
      apply_operator(FUNC_LOWER, 5'd31, 5'd17, 10'd6);
      apply_operator(FUNC_RAISE_RAISE, 5'd0, 5'd0, 10'd4);
   endtask

   // Fill the low entries, search all of them, then run with a size past the
   // depth. Every later search stays inside these filled entries.
   task automatic test_filled_table();
      int                pick;
      logic [SITE_W-1:0] site;
      new_family();
      for (int k = 0; k < FILL_ENTRIES; k++) begin
         load_entry(INDEX_W'(k), family_word());
      end
      write_table_size(RESULT_W'(FILL_ENTRIES));
      repeat (4) begin
         apply_operator(random_operator(), pick_site(), pick_site(),
                        INDEX_W'($urandom_range(0, FILL_ENTRIES - 1)));
      end
      apply_operator(FUNC_RAISE_RAISE, pick_site(), pick_site(), '1);
      // With the size past the depth, each lookup gets a matching entry first.
      write_table_size(SIZE_BEYOND_DEPTH);
      repeat (3) begin
         site = pick_site();
         pick = $urandom_range(0, FILL_ENTRIES - 2);
         load_entry(INDEX_W'(pick + 1), step_digit(table_words[pick], site, 1'b1));
         apply_operator(FUNC_RAISE, site, pick_site(), INDEX_W'(pick));
      end
      // A zero digit under the z operator reports the full size register.
      load_entry('0, '0);
      apply_operator(FUNC_LOWER_Z, pick_site(), pick_site(), '0);
      write_table_size(RESULT_W'(FILL_ENTRIES - 1));
      repeat (2) begin
         apply_operator(random_operator(), pick_site(), pick_site(),
                        INDEX_W'($urandom_range(0, FILL_ENTRIES - 1)));
      end
   endtask

   // Hold the result side off while items keep coming, then pause the sender.
   task automatic test_output_stall();
      new_family();
      write_table_size(RESULT_W'(16));
      for (int k = 0; k < 16; k++) begin
         load_entry(INDEX_W'(k), family_word());
      end
      no_idle = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (10) begin
         apply_operator(random_operator(), pick_site(), pick_site(),
                        INDEX_W'($urandom_range(0, 15)));
      end
      settle();
      no_idle = 1'b0;
      repeat (6) begin
         apply_operator(random_operator(), pick_site(), pick_site(),
                        INDEX_W'($urandom_range(0, 15)));
      end
   endtask

   // Rounds of a fresh word family, a new table size and a burst of items.
   task automatic test_random_mix();
      int                 start_count;
      int                 span;
      int                 refill;
      int                 ops;
      int                 roll;
      logic [INDEX_W-1:0] idx;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         new_family();
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            span = 0;
         end else if (roll == 1) begin
            span = $urandom_range(64, FILL_ENTRIES);
         end else begin
            span = $urandom_range(1, 40);
         end
         write_table_size(RESULT_W'(span));
         no_idle = ($urandom_range(0, 5) == 0);
         refill = (span < 40) ? span : 40;
         for (int k = 0; k < refill; k++) begin
            load_entry(INDEX_W'(k), family_word());
         end
         // Long searches are slow, so large tables get only a few lookups.
         ops = (span > 40) ? $urandom_range(2, 4) : $urandom_range(5, 25);
         repeat (ops) begin
            roll = $urandom_range(0, 99);
            if (refill > 0) begin
               idx = INDEX_W'($urandom_range(0, refill - 1));
            end else begin
               idx = INDEX_W'($urandom_range(0, FILL_ENTRIES - 1));
            end
            if (roll < 8) begin
               load_entry(INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                          (roll < 4) ? family_word() : {$urandom, $urandom});
            end else if (roll < 85) begin
               apply_operator(random_operator(), pick_site(), pick_site(), idx);
            end else begin
               apply_operator(random_operator(),
                              SITE_W'($urandom_range(0, SITE_CODES - 1)),
                              SITE_W'($urandom_range(0, SITE_CODES - 1)),
                              INDEX_W'($urandom_range(0, FILL_ENTRIES - 1)));
            end
         end
      end
      no_idle = 1'b0;
   endtask

   // Result side: random ready pattern, plus a long hold when one is asked.
   initial begin : result_sink
      int run;
      int gap;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         rsp_bus.ready <= 1'b1;
         run = no_idle ? 1 : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Compare each accepted result with the oldest outstanding lookup.
   always @(posedge clock) begin : result_check
      lookup_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_lookups.size() == 0) begin
            note_failure($sformatf("result with none pending: index %0d coefficient %0d",
                                   rsp_bus.result_index, rsp_bus.coefficient));
         end else begin
            want = awaited_lookups.pop_front();
            if (rsp_bus.result_index !== want.result_index) begin
               note_failure($sformatf("result_index mismatch: expected %0d, got %0d",
                                      want.result_index, rsp_bus.result_index));
            end
            if (rsp_bus.coefficient !== want.coefficient) begin
               note_failure($sformatf("coefficient mismatch: expected %0d, got %0d",
                                      want.coefficient, rsp_bus.coefficient));
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Test sequence.
   initial begin : main_flow
      failures            = 0;
      items_sent          = 0;
      rsp_hold_cycles     = 0;
      no_idle             = 1'b0;
      table_size_now      = '0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_LOAD;
      req_bus.site_i      = '0;
      req_bus.site_j      = '0;
      req_bus.state_index = '0;
      req_bus.entry_word  = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      foreach (table_words[k]) begin
         table_words[k] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_directed_cases();
      test_filled_table();
      test_output_stall();
      test_random_mix();

      // Let every outstanding lookup come back before judging the run.
      req_bus.valid <= 1'b0;
      while (awaited_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && awaited_lookups.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* clock_shift_state_lookup.f */
+incdir+hw/rtl
hw/rtl/csl_pkg.sv
hw/rtl/csl_if.sv
hw/rtl/csl_datapath.sv
hw/rtl/csl_controller.sv
hw/rtl/clock_shift_state_lookup.sv
tb/sv/clock_shift_state_lookup_test.sv
